[hdl/max_priority_scan_queue_defines.svh]
// Assertion helpers shared by the queue RTL.
// Both macros expect clk and rst to be visible where they are used.
`ifndef MAX_PRIORITY_SCAN_QUEUE_DEFINES_SVH
`define MAX_PRIORITY_SCAN_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MPSQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mpsq_pkg.sv]
`timescale 1ns / 1ps

package mpsq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 16;
  localparam int PRIO_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  // one read beat coming back from the slot store during a scan
  typedef struct packed {
    logic vld;
    logic first;
    idx_t idx;
  } beat_t;

  typedef struct packed {
    idx_t  idx;
    slot_t slot;
  } best_t;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

endpackage

[hdl/max_priority_scan_queue.sv]
`timescale 1ns / 1ps
// Enqueue or dequeue on empty: the request goes from idle straight to the done state.
// Dequeue of n entries: a scan over all n slots through one read port on the slot store and
// one compare unit, then a shift of the later slots down by one through the same read port.
// One item in flight; the output register lets the next item start while a result waits.
// Synchronous active-high reset empties the queue and drops any pending result.
`include "max_priority_scan_queue_defines.svh"

module max_priority_scan_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        mode,
  input  logic [mpsq_pkg::ID_W-1:0]   proc_id,
  input  logic [mpsq_pkg::PRIO_W-1:0] priority_req,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        out_valid,
  output logic [mpsq_pkg::ID_W-1:0]   out_id,
  output logic [mpsq_pkg::PRIO_W-1:0] out_priority,
  output logic                        dropped,
  output logic                        is_empty
);
  import mpsq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_LOCATE = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;
  cnt_t   count;
  cnt_t   scan_idx;

  slot_t  mem [DEPTH];
  slot_t  rd_data;
  idx_t   rd_addr;
  idx_t   rd_idx;
  idx_t   wr_idx;
  logic   rd_vld;
  logic   rd_first;
  logic   issue;
  logic   req_accept;
  logic   full;
  logic   enq_wr;
  logic   sh_wr;
  logic   out_free;
  beat_t  beat;
  best_t  best;

  // staged result, moved to the output register when it frees up
  logic              st_valid;
  logic [ID_W-1:0]   st_id;
  logic [PRIO_W-1:0] st_prio;
  logic              st_drop;
  logic              st_empty;

  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign full       = (count >= cnt_t'(DEPTH));
  assign enq_wr     = req_accept && (mode == MODE_ENQ) && !full;
  assign issue      = ((state == ST_SCAN) || (state == ST_SHIFT)) && (scan_idx < count);
  assign rd_addr    = scan_idx[IDX_W-1:0];
  assign sh_wr      = rd_vld && (state == ST_SHIFT);
  assign wr_idx     = rd_idx - idx_t'(1);
  assign out_free   = !res_valid || !res_stall;

  assign beat.vld   = rd_vld && (state == ST_SCAN);
  assign beat.first = rd_first;
  assign beat.idx   = rd_idx;

  mpsq_max_track u_track (
    .clk  (clk),
    .beat (beat),
    .slot (rd_data),
    .best (best)
  );

  // slot store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (enq_wr) begin
      mem[count[IDX_W-1:0]] <= '{id: proc_id, prio: priority_req};
    end else if (sh_wr) begin
      mem[wr_idx] <= rd_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_idx   <= rd_addr;
    rd_first <= (state == ST_SCAN) && (scan_idx == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        scan_idx <= scan_idx + cnt_t'(1);
      end
      // ST_DONE reloads the output register itself
      if (res_valid && !res_stall && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_accept) begin
            st_valid <= 1'b0;
            st_id    <= '0;
            st_prio  <= '0;
            if (mode == MODE_ENQ) begin
              st_drop  <= full;
              st_empty <= 1'b0;
              if (!full) begin
                count <= count + cnt_t'(1);
              end
              state <= ST_DONE;
            end else if (count == '0) begin
              st_drop  <= 1'b0;
              st_empty <= 1'b1;
              state    <= ST_DONE;
            end else begin
              scan_idx <= '0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // leave once every read has been issued and its beat consumed
          if (!issue && !rd_vld) begin
            state <= ST_LOCATE;
          end
        end
        ST_LOCATE: begin
          st_valid <= 1'b1;
          st_id    <= best.slot.id;
          st_prio  <= best.slot.prio;
          st_drop  <= 1'b0;
          st_empty <= (count == cnt_t'(1));
          scan_idx <= cnt_t'(best.idx) + cnt_t'(1);
          state    <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (!issue && !rd_vld) begin
            count <= count - cnt_t'(1);
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid    <= st_valid;
            out_id       <= st_id;
            out_priority <= st_prio;
            dropped      <= st_drop;
            is_empty     <= st_empty;
            res_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MPSQ_ASSERT_NEXT(a_busy_after_accept, req_accept, req_stall, "no stall after accept")
  `MPSQ_ASSERT(a_count_bound, 1'b1, count <= cnt_t'(DEPTH), "entry count above depth")
  `MPSQ_ASSERT(a_result_flags, res_valid && dropped, !out_valid && !is_empty, "bad drop flags")

endmodule

[hdl/mpsq_max_track.sv]
`timescale 1ns / 1ps

module mpsq_max_track (
  input  logic            clk,
  input  mpsq_pkg::beat_t beat,
  input  mpsq_pkg::slot_t slot,
  output mpsq_pkg::best_t best
);
  import mpsq_pkg::*;

  best_t best_q;
  logic  take;

  // strict greater-than keeps the earliest entry on a tie
  assign take = beat.vld && (beat.first || (slot.prio > best_q.slot.prio));

  always_ff @(posedge clk) begin
    if (take) begin
      best_q.idx  <= beat.idx;
      best_q.slot <= slot;
    end
  end

  assign best = best_q;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mpsq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_OPS = 500;

  typedef struct packed {
    logic              m;
    logic [ID_W-1:0]   pid;
    logic [PRIO_W-1:0] pr;
  } queue_op_t;

  typedef struct packed {
    logic              served;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              dropped;
    logic              empty;
  } queue_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic mode = MODE_ENQ;
  logic [ID_W-1:0] proc_id = '0;
  logic [PRIO_W-1:0] priority_req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic out_valid;
  logic [ID_W-1:0] out_id;
  logic [PRIO_W-1:0] out_priority;
  logic dropped;
  logic is_empty;

  queue_op_t ops_to_send[$];
  queue_res_t awaited_outcomes[$];

  // shadow copy of the entry store, kept in arrival order
  logic [ID_W-1:0] shadow_id[DEPTH];
  logic [PRIO_W-1:0] shadow_prio[DEPTH];
  int shadow_count = 0;

  int cycle_count = 0;
  int error_count = 0;
  bit req_taken = 1'b0;

  max_priority_scan_queue u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .mode(mode),
    .proc_id(proc_id),
    .priority_req(priority_req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .out_valid(out_valid),
    .out_id(out_id),
    .out_priority(out_priority),
    .dropped(dropped),
    .is_empty(is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one op to the shadow queue and return what the block should report
  function automatic queue_res_t queue_op_outcome(logic m, logic [ID_W-1:0] pid,
                                                  logic [PRIO_W-1:0] pr);
    queue_res_t r;
    int best;
    r = '0;
    if (m == MODE_ENQ) begin
      if (shadow_count < DEPTH) begin
        shadow_id[shadow_count] = pid;
        shadow_prio[shadow_count] = pr;
        shadow_count++;
      end else begin
        r.dropped = 1'b1;
      end
    end else if (shadow_count > 0) begin
      best = 0;
      // strict compare: on a tie the earliest entry stays the winner
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_prio[i] > shadow_prio[best]) best = i;
      end
      r.served = 1'b1;
      r.id = shadow_id[best];
      r.prio = shadow_prio[best];
      for (int i = best + 1; i < shadow_count; i++) begin
        shadow_id[i-1] = shadow_id[i];
        shadow_prio[i-1] = shadow_prio[i];
      end
      shadow_count--;
    end
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  // long window in which neither the driver nor the result side idles
  function bit idle_now();
    if (cycle_count >= 1000 && cycle_count < 3000) return 1'b0;
    return $urandom_range(99) < 21;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [PRIO_W-1:0] got, logic [PRIO_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic add_op(logic m, logic [ID_W-1:0] pid, logic [PRIO_W-1:0] pr);
    queue_op_t op;
    op.m = m;
    op.pid = pid;
    op.pr = pr;
    ops_to_send.push_back(op);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // driver: present the next op once the current one has transferred
  always @(negedge clk) begin : drive
    queue_op_t op;
    if (!rst && (!req_valid || req_taken)) begin
      if (ops_to_send.size() != 0 && !idle_now()) begin
        op = ops_to_send.pop_front();
        req_valid <= 1'b1;
        mode <= op.m;
        proc_id <= op.pid;
        priority_req <= op.pr;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_stall <= idle_now();
  end

  // monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin : monitor
    queue_res_t due;
    req_taken = !rst && req_valid && !req_stall;
    if (req_taken) awaited_outcomes.push_back(queue_op_outcome(mode, proc_id, priority_req));
    if (!rst && res_valid && !res_stall) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        due = awaited_outcomes.pop_front();
        check_field("out_valid", out_valid, due.served);
        check_field("out_id", out_id, due.id);
        check_field("out_priority", out_priority, due.prio);
        check_field("dropped", dropped, due.dropped);
        check_field("is_empty", is_empty, due.empty);
      end
    end
  end

  initial begin : stimulus
    int n;
    int bias;
    int burst;
    int sel;
    logic m;
    logic [PRIO_W-1:0] pr;

    // dequeue on empty, payload ignored
    add_op(MODE_DEQ, 16'h1234, 32'hDEAD_BEEF);
    add_op(MODE_ENQ, 16'h0000, 32'h0000_0000);
    add_op(MODE_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(MODE_ENQ, 16'h0001, 32'h0000_0005);
    add_op(MODE_ENQ, 16'h0002, 32'h0000_0005);
    add_op(MODE_ENQ, 16'h0003, 32'hFFFF_FFFF);
    add_op(MODE_ENQ, 16'hAAAA, 32'h8000_0000);
    for (int i = 0; i < 10; i++) add_op(MODE_ENQ, 16'h0100 + 16'(i), 32'h7);
    // queue is full now
    add_op(MODE_ENQ, 16'h5555, 32'h5555_5555);
    // max priority tie, then the high-bit entry
    add_op(MODE_DEQ, 16'h0000, 32'h0);
    add_op(MODE_DEQ, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(MODE_DEQ, 16'h0000, 32'h0);

    // bursts with an enqueue bias so the queue swings between full and empty
    n = 0;
    while (n < RANDOM_OPS) begin
      case ($urandom_range(2))
        0: bias = 20;
        1: bias = 50;
        default: bias = 85;
      endcase
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        m = ($urandom_range(99) < bias) ? MODE_ENQ : MODE_DEQ;
        sel = $urandom_range(9);
        case (sel) inside
          [0:3]: pr = $urandom_range(3);
          4: pr = 32'hFFFF_FFFF;
          5: pr = 32'h0;
          6: pr = 32'hFFFF_FFFF - $urandom_range(3);
          default: pr = $urandom();
        endcase
        add_op(m, 16'($urandom_range(65535)), pr);
        n++;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || req_valid || awaited_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mpsq_pkg.sv
hdl/mpsq_max_track.sv
hdl/max_priority_scan_queue.sv
dv/testbench.sv
